@@ hw/rtl/smf_pkg.sv @@
package smf_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int SAMPLE_W   = 16;
	localparam int SIZE_W     = 5;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(10);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_OLD_RD,
		ST_OLD_EV,
		ST_SRT_RD,
		ST_SRT_EV,
		ST_TAIL,
		ST_MED_LO,
		ST_MED_HI,
		ST_MED_SUM,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/sliding_median_filter_unit.sv @@
// Sliding window median over the last window_size signed 16-bit samples (0 acts as 1,
// above 16 saturates to 16). The block holds the raw window in one memory and a sorted
// copy in a second; each new sample replaces the oldest value in the sorted copy in one
// scan, then the median is read from the middle entries (an even window averages the
// middle pair, rounding toward minus infinity). One sample is taken at a time: the next
// beat is held off until the current sample has been merged and its median passed on.
// The scan reads the sorted memory one entry at a time through its single read port.
// The first sample after reset or after a window_size write refills the window and
// comes back unchanged. A median still held by out_stall delays the next one.
// window_size is taken only while the block is idle, and a new sample is held off
// while a write waits.
module sliding_median_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [smf_pkg::SIZE_W-1:0]    window_size,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [smf_pkg::SAMPLE_W-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [smf_pkg::SAMPLE_W-1:0] median
);
	import smf_pkg::*;

	state_t state_q, state_d;

	logic [SIZE_W-1:0] window_size_q;
	logic              pending_q;
	addr_t             wpos_q;
	addr_t             rk_q, wk_q;
	cnt_t              left_q;
	logic              up_q, skipped_q, inserted_q;
	logic              out_valid_q;

	cnt_t    n_q;
	sample_t sample_q, old_q, lo_q, res_q, median_q;

	sample_t win_mem_q [MAX_WINDOW];
	sample_t srt_mem_q [MAX_WINDOW];
	sample_t win_rdata_q, srt_rdata_q;

	logic    win_we, srt_we;
	addr_t   win_waddr, win_raddr, srt_waddr, srt_raddr;
	sample_t win_wdata, srt_wdata;

	cnt_t    active_n;
	addr_t   wpos_fix;
	cnt_t    wpos_inc;
	logic    in_beat, cfg_beat, out_free, last_elem;
	logic    skip_hit, ins_hit;
	logic signed [SAMPLE_W:0] mid_sum;

	assign in_beat   = in_valid && !in_stall;
	assign cfg_beat  = cfg_valid && cfg_ready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE) || cfg_valid;
	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign last_elem = (left_q == cnt_t'(1));

	always_comb begin
		if (window_size_q == '0) begin
			active_n = cnt_t'(1);
		end else if (32'(window_size_q) > 32'(MAX_WINDOW)) begin
			active_n = cnt_t'(MAX_WINDOW);
		end else begin
			active_n = cnt_t'(window_size_q);
		end
	end

	assign wpos_fix = (cnt_t'(wpos_q) >= active_n) ? '0 : wpos_q;
	assign wpos_inc = cnt_t'(wpos_q) + cnt_t'(1);

	// merge step: drop one copy of the oldest value, place the new sample before x
	assign skip_hit = !skipped_q && (srt_rdata_q == old_q);
	assign ins_hit  = !inserted_q &&
		(up_q ? (srt_rdata_q > sample_q) : (srt_rdata_q < sample_q));

	assign mid_sum = {lo_q[SAMPLE_W-1], lo_q} + {srt_rdata_q[SAMPLE_W-1], srt_rdata_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					state_d = pending_q ? ST_FILL : ST_OLD_RD;
				end
			end
			ST_FILL: begin
				if (last_elem) begin
					state_d = ST_DONE;
				end
			end
			ST_OLD_RD:  state_d = ST_OLD_EV;
			ST_OLD_EV:  state_d = ST_SRT_RD;
			ST_SRT_RD:  state_d = ST_SRT_EV;
			ST_SRT_EV: begin
				if (skip_hit || !ins_hit) begin
					state_d = last_elem ? ST_TAIL : ST_SRT_RD;
				end
			end
			ST_TAIL:    state_d = ST_MED_LO;
			ST_MED_LO:  state_d = ST_MED_HI;
			ST_MED_HI:  state_d = ST_MED_SUM;
			ST_MED_SUM: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		win_we    = 1'b0;
		win_waddr = wpos_q;
		win_wdata = sample_q;
		win_raddr = wpos_q;
		srt_we    = 1'b0;
		srt_waddr = wk_q;
		srt_wdata = sample_q;
		srt_raddr = rk_q;
		unique case (state_q)
			ST_FILL: begin
				win_we    = 1'b1;
				win_waddr = wk_q;
				srt_we    = 1'b1;
			end
			ST_OLD_EV: begin
				win_we = 1'b1;
			end
			ST_SRT_EV: begin
				if (!skip_hit) begin
					srt_we    = 1'b1;
					srt_wdata = ins_hit ? sample_q : srt_rdata_q;
				end
			end
			ST_TAIL: begin
				srt_we = !inserted_q;
			end
			ST_MED_LO: begin
				srt_raddr = addr_t'((n_q - cnt_t'(1)) >> 1);
			end
			ST_MED_HI: begin
				srt_raddr = addr_t'(n_q >> 1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem_q[win_waddr] <= win_wdata;
		end
		win_rdata_q <= win_mem_q[win_raddr];
	end

	always_ff @(posedge clk) begin
		if (srt_we) begin
			srt_mem_q[srt_waddr] <= srt_wdata;
		end
		srt_rdata_q <= srt_mem_q[srt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= SIZE_RESET;
			pending_q     <= 1'b1;
			wpos_q        <= '0;
			rk_q          <= '0;
			wk_q          <= '0;
			left_q        <= '0;
			up_q          <= 1'b0;
			skipped_q     <= 1'b0;
			inserted_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_beat) begin
						window_size_q <= window_size;
						wpos_q        <= '0;
						pending_q     <= 1'b1;
					end else if (in_beat) begin
						wpos_q <= wpos_fix;
						wk_q   <= '0;
						left_q <= active_n;
					end
				end
				ST_FILL: begin
					wk_q   <= wk_q + addr_t'(1);
					left_q <= left_q - cnt_t'(1);
					if (last_elem) begin
						pending_q <= 1'b0;
					end
				end
				ST_OLD_EV: begin
					wpos_q     <= (wpos_inc >= n_q) ? '0 : addr_t'(wpos_inc);
					up_q       <= (sample_q >= win_rdata_q);
					rk_q       <= (sample_q >= win_rdata_q) ? '0 : addr_t'(n_q - cnt_t'(1));
					wk_q       <= (sample_q >= win_rdata_q) ? '0 : addr_t'(n_q - cnt_t'(1));
					left_q     <= n_q;
					skipped_q  <= 1'b0;
					inserted_q <= 1'b0;
				end
				ST_SRT_EV: begin
					if (skip_hit) begin
						skipped_q <= 1'b1;
						rk_q      <= up_q ? rk_q + addr_t'(1) : rk_q - addr_t'(1);
						left_q    <= left_q - cnt_t'(1);
					end else begin
						wk_q <= up_q ? wk_q + addr_t'(1) : wk_q - addr_t'(1);
						if (ins_hit) begin
							inserted_q <= 1'b1;
						end else begin
							rk_q   <= up_q ? rk_q + addr_t'(1) : rk_q - addr_t'(1);
							left_q <= left_q - cnt_t'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_q <= sample;
			n_q      <= active_n;
		end
		if (state_q == ST_OLD_EV) begin
			old_q <= win_rdata_q;
		end
		if (state_q == ST_FILL) begin
			res_q <= sample_q;
		end
		if (state_q == ST_MED_HI) begin
			lo_q <= srt_rdata_q;
		end
		if (state_q == ST_MED_SUM) begin
			res_q <= sample_t'(mid_sum >>> 1);
		end
		if (state_q == ST_DONE && out_free) begin
			median_q <= res_q;
		end
	end

	a_cfg_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_beat |=> pending_q && (wpos_q == '0))
		else $error("window_size write did not rearm the window fill");

	a_no_cfg_and_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_beat && in_beat))
		else $error("sample beat taken together with a window_size write");

	a_insert_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRT_EV) && ins_hit && !skip_hit |-> (wk_q != rk_q))
		else $error("sorted insert overwrites the entry being read");

	a_oldest_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL) |-> skipped_q)
		else $error("oldest value not found in sorted store");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_free |=> out_valid_q && (state_q == ST_IDLE))
		else $error("median beat lost on leaving done");

endmodule

@@ tb/tb_sliding_median_filter_unit.sv @@
`timescale 1ns / 1ps

module tb_sliding_median_filter_unit;
	import smf_pkg::*;

	class median_scoreboard;
		sample_t            window_copy[MAX_WINDOW];
		int unsigned        slot;
		bit                 refill;
		logic [SIZE_W-1:0]  size_reg;
		sample_t            expected_medians[$];
		int                 mismatches;

		function new();
			foreach (window_copy[i])
				window_copy[i] = '0;
			slot = 0;
			refill = 1'b1;
			size_reg = SIZE_RESET;
			mismatches = 0;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %0d: %s", mismatches, msg);
		endfunction

		function void write_window_size(logic [SIZE_W-1:0] value);
			size_reg = value;
			slot = 0;
			refill = 1'b1;
		endfunction

		function void note_sample(sample_t s);
			int ordered[MAX_WINDOW];
			int n;
			int i;
			int j;
			int v;
			int sum;
			sample_t med;
			n = (size_reg == 0) ? 1 : ((size_reg > MAX_WINDOW) ? MAX_WINDOW : int'(size_reg));
			if (refill) begin
				refill = 1'b0;
				for (i = 0; i < n; i++)
					window_copy[i] = s;
				med = s;
			end else begin
				if (slot >= n)
					slot = 0;
				window_copy[slot] = s;
				slot++;
				if (slot >= n)
					slot = 0;
				for (i = 0; i < n; i++) begin
					v = window_copy[i];
					j = i;
					while (j > 0 && ordered[j-1] > v) begin
						ordered[j] = ordered[j-1];
						j--;
					end
					ordered[j] = v;
				end
				if ((n % 2) == 0) begin
					sum = ordered[n/2-1] + ordered[n/2];
					med = sample_t'(sum >>> 1);
				end else begin
					med = sample_t'(ordered[n/2]);
				end
			end
			expected_medians.push_back(med);
		endfunction

		function void check_median(sample_t got);
			sample_t want;
			if (expected_medians.size() == 0) begin
				report($sformatf("median %0d with no sample pending", got));
			end else begin
				want = expected_medians.pop_front();
				if (got !== want)
					report($sformatf("median expected %0d, got %0d", want, got));
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [SIZE_W-1:0]  window_size;
	logic               in_valid;
	logic               in_stall;
	sample_t            sample;
	logic               out_valid;
	logic               out_stall;
	sample_t            median;

	int                 send_idle_pct;
	int                 recv_stall_pct;
	median_scoreboard   sb;

	logic [SIZE_W-1:0]  phase_sizes[8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd15, 5'd3};

	sliding_median_filter_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.window_size (window_size),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.median      (median)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		window_size = '0;
		in_valid = 1'b0;
		sample = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sb = new();
	end

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall)
			sb.check_median(median);
	end

	initial begin
		#8_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 59;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 59;
			end
			default: begin
				send_idle_pct = 14;
				recv_stall_pct = 14;
			end
		endcase
	endtask

	// one sample beat, valid stays high into the next beat unless the sender idles
	task automatic send_sample(input sample_t s);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (in_stall);
		sb.note_sample(s);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_medians.size() != 0);
	endtask

	task automatic write_window(input logic [SIZE_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		window_size <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_window_size(value);
		cfg_valid <= 1'b0;
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return sample_t'(-32768);
					1: return sample_t'(32767);
					2: return sample_t'(0);
					default: return sample_t'(-1);
				endcase
			end
			1, 2: return sample_t'(int'($urandom_range(15)) - 8);
			default: return sample_t'($urandom);
		endcase
	endfunction

	initial begin
		int p;
		int k;
		logic [SIZE_W-1:0] sz;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of ten, even size mixing both extremes
		send_sample(sample_t'(32767));
		repeat (5) send_sample(sample_t'(-32768));
		write_window(5'd2);
		send_sample(sample_t'(32767));
		send_sample(sample_t'(32767));
		write_window(5'd0);
		send_sample(sample_t'(-32768));
		send_sample(sample_t'(-1));
		write_window(5'd31);
		send_sample(sample_t'(5));
		send_sample(sample_t'(-5));
		send_sample(sample_t'(0));
		write_window(5'd3);
		send_sample(sample_t'(1));
		send_sample(sample_t'(-1));
		send_sample(sample_t'(2));
		write_window(5'd16);
		send_sample(sample_t'(-32768));
		send_sample(sample_t'(-32767));

		for (p = 0; p < 24; p++) begin
			sz = (p < 8) ? phase_sizes[p] : 5'($urandom_range(31));
			write_window(sz);
			set_idling(p);
			for (k = 0; k < 80; k++) begin
				if (k == 40)
					drain_results();
				send_sample(pick_sample());
			end
		end

		in_valid <= 1'b0;
		while (sb.expected_medians.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.expected_medians.size() != 0)
			sb.report($sformatf("%0d medians never arrived", sb.expected_medians.size()));
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sliding_median_filter_unit.f @@
hw/rtl/smf_pkg.sv
hw/rtl/sliding_median_filter_unit.sv
tb/tb_sliding_median_filter_unit.sv
